// File: rtl/ptcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_pkg: shared types and constants for the category probability block
// Holds the exponent step table, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ptcp_pkg;

  localparam int MaxThresholdsDefault = 4;
  localparam int NumThrRegs = 4;
  localparam int ExpSteps = 17;

  // Configuration register indexes.
  localparam logic [2:0] RegMode  = 3'd0;
  localparam logic [2:0] RegDisc  = 3'd1;
  localparam logic [2:0] RegCount = 3'd2;
  localparam logic [2:0] RegThr1  = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZMUL,
    ST_ZFIN,
    ST_EXP,
    ST_EXP_MUL,
    ST_DIV_START,
    ST_LOG_DIV,
    ST_NORM_DIV,
    ST_EMIT
  } state_t;

  // exp(-2^(i-12)) in Q1.30.
  function automatic logic [30:0] exp_step(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd1073479712;
      5'd1:  v = 31'd1073217664;
      5'd2:  v = 31'd1072693760;
      5'd3:  v = 31'd1071646719;
      5'd4:  v = 31'd1069555701;
      5'd5:  v = 31'd1065385899;
      5'd6:  v = 31'd1057095000;
      5'd7:  v = 31'd1040706261;
      5'd8:  v = 31'd1008687096;
      5'd9:  v = 31'd947573834;
      5'd10: v = 31'd836230973;
      5'd11: v = 31'd651257337;
      5'd12: v = 31'd395007542;
      5'd13: v = 31'd145315154;
      5'd14: v = 31'd19666268;
      5'd15: v = 31'd360200;
      5'd16: v = 31'd121;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ptcp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_divider: radix-2 restoring divider
// Unsigned 61-bit dividend over 34-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ptcp_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [60:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [60:0] quotient
);

  logic [5:0]  count;
  logic        busy;
  logic [33:0] rem;
  logic [60:0] quo;
  logic [34:0] trial;

  assign trial = {rem[33:0], quo[60]} - {1'b0, divisor};

  // One shift-subtract step per cycle while busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd60;
      end else if (busy) begin
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[34]) begin
        rem <= trial[33:0];
        quo <= {quo[59:0], 1'b1};
      end else begin
        rem <= {rem[32:0], quo[60]};
        quo <= {quo[59:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/polytomous_item_category_probs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polytomous_item_category_probs: per-category response probabilities
// Partial credit softmax or graded response logistic differences for theta.
// ----------------------------------------------------------------------------
// Usage: theta arrives on theta_valid/theta_stall. After a transfer the block
// stalls its input until every category result has been transferred out on
// result_valid/result_stall, one transfer per category 0..n, with last set on
// category n. Configuration must be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Sequencing: per threshold the ZMUL and ZFIN states form the slope product. The
// softmax mode then runs one exponent pass per category on the shared 31x31
// multiplier and one division per category; graded response runs one exponent
// pass and one division per threshold. All divisions use the shared divider.
// With no thresholds the block goes from idle straight to emitting the single
// result. The divider and the exponent multiplier take most of the time per item.
// Reset restores the register reset values and empties the block. A stalled
// result simply holds; the sequencer waits for its transfer.
// ----------------------------------------------------------------------------
module polytomous_item_category_probs #(
  parameter int MAX_THRESHOLDS = ptcp_pkg::MaxThresholdsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               theta_valid,
  output logic               theta_stall,
  input  logic signed [15:0] theta,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         category,
  output logic [15:0]        probability,
  output logic               last
);

  localparam int Cap = (MAX_THRESHOLDS < ptcp_pkg::NumThrRegs) ?
                       MAX_THRESHOLDS : ptcp_pkg::NumThrRegs;
  localparam logic [2:0] CapW = 3'(Cap);
  localparam logic [30:0] OneQ30 = 31'h40000000;

  // Configuration registers.
  logic               mode;
  logic [14:0]        disc;
  logic [2:0]         count;
  logic signed [15:0] thr [ptcp_pkg::NumThrRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      disc <= 15'd4096;
      count <= 3'd1;
      for (int i = 0; i < ptcp_pkg::NumThrRegs; i++) thr[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ptcp_pkg::RegMode) mode <= cfg_data[0];
      else if (cfg_index == ptcp_pkg::RegDisc) disc <= cfg_data[14:0];
      else if (cfg_index == ptcp_pkg::RegCount) count <= cfg_data[2:0];
      else if (cfg_index >= ptcp_pkg::RegThr1 &&
               cfg_index < ptcp_pkg::RegThr1 + 3'(ptcp_pkg::NumThrRegs))
        thr[2'(cfg_index - ptcp_pkg::RegThr1)] <= cfg_data;
    end
  end

  ptcp_pkg::state_t state, state_next;

  logic [2:0]          n;        // thresholds in use for this item
  logic [2:0]          k;        // category / threshold counter
  logic [4:0]          bitn;     // exponent step index
  logic signed [15:0]  th;
  logic signed [16:0]  diff;
  logic signed [32:0]  prod;
  logic signed [21:0]  zval [ptcp_pkg::NumThrRegs + 1]; // z, then sums s_k
  logic signed [24:0]  smax;
  logic [17:0]         u;
  logic [30:0]         r;
  logic [61:0]         mprod;
  logic [30:0]         e [ptcp_pkg::NumThrRegs + 1];
  logic [33:0]         esum;
  logic [30:0]         pstar [ptcp_pkg::NumThrRegs + 2];
  logic [15:0]         prob [ptcp_pkg::NumThrRegs + 1];
  logic                div_start, div_done;
  logic [60:0]         div_num, div_q;
  logic [33:0]         div_den;
  logic [2:0]          n_sel;
  logic signed [24:0]  z_sel, s_k;
  logic [24:0]         mag;

  ptcp_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  assign n_sel = (count > CapW) ? CapW : count;
  assign diff = 17'(th) - 17'(thr[2'(k - 3'd1)]);
  assign s_k = 25'(zval[k]);
  assign z_sel = (mode) ? s_k : smax - s_k;
  assign mag = (z_sel < 0) ? 25'(-z_sel) : 25'(z_sel);
  assign mprod = r * ptcp_pkg::exp_step(bitn);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ptcp_pkg::ST_IDLE: if (theta_valid) state_next =
        (n_sel == 3'd0) ? ptcp_pkg::ST_EMIT : ptcp_pkg::ST_ZMUL;
      ptcp_pkg::ST_ZMUL: state_next = ptcp_pkg::ST_ZFIN;
      ptcp_pkg::ST_ZFIN: state_next = (k == n) ? ptcp_pkg::ST_EXP : ptcp_pkg::ST_ZMUL;
      ptcp_pkg::ST_EXP: state_next = ptcp_pkg::ST_EXP_MUL;
      ptcp_pkg::ST_EXP_MUL: if (bitn == 5'd16) begin
        if (mode || k == n) state_next = ptcp_pkg::ST_DIV_START;
        else state_next = ptcp_pkg::ST_EXP;
      end
      // The operands have settled here, so the divider can latch them.
      ptcp_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_next = mode ? ptcp_pkg::ST_LOG_DIV : ptcp_pkg::ST_NORM_DIV;
      end
      ptcp_pkg::ST_LOG_DIV: if (div_done)
        state_next = (k == n) ? ptcp_pkg::ST_EMIT : ptcp_pkg::ST_EXP;
      ptcp_pkg::ST_NORM_DIV: if (div_done)
        state_next = (k == n) ? ptcp_pkg::ST_EMIT : ptcp_pkg::ST_DIV_START;
      ptcp_pkg::ST_EMIT: if (!result_stall && last) state_next = ptcp_pkg::ST_IDLE;
      default: state_next = ptcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ptcp_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Divider operands: logistic 2^60/D or normalization e_k*2^16/S, rounded.
  always_comb begin
    if (mode) begin
      div_den = 34'(OneQ30) + 34'(r);
      div_num = 61'(62'd1 << 60) + 61'(div_den >> 1);
    end else begin
      div_den = esum;
      div_num = 61'({e[k], 16'd0}) + 61'(esum >> 1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ptcp_pkg::ST_IDLE: begin
        th <= theta;
        n <= n_sel;
        k <= (n_sel == 3'd0) ? 3'd0 : 3'd1;
        zval[0] <= '0;
        smax <= '0;
        esum <= '0;
        pstar[0] <= OneQ30;
        prob[0] <= 16'hFFFF;
      end
      ptcp_pkg::ST_ZMUL: prod <= $signed({1'b0, disc}) * diff;
      ptcp_pkg::ST_ZFIN: begin
        // Floor shift, then running sum in softmax mode.
        if (mode) zval[k] <= 22'(prod >>> 12);
        else begin
          zval[k] <= 22'(zval[k - 3'd1] + 22'(prod >>> 12));
          if (25'(zval[k - 3'd1] + 22'(prod >>> 12)) > smax)
            smax <= 25'(zval[k - 3'd1] + 22'(prod >>> 12));
        end
        if (k == n) k <= mode ? 3'd1 : 3'd0;
        else k <= k + 3'd1;
      end
      ptcp_pkg::ST_EXP: begin
        u <= (mag >= 25'(1 << 17)) ? 18'h20000 : 18'(mag);
        r <= OneQ30;
        bitn <= '0;
      end
      ptcp_pkg::ST_EXP_MUL: begin
        if (u[17]) r <= '0;
        else if (u[bitn]) r <= 31'((mprod + 62'(1 << 29)) >> 30);
        bitn <= bitn + 5'd1;
        if (bitn == 5'd16 && !mode) begin
          e[k] <= u[17] ? 31'd0 : ((u[16] ? 31'((mprod + 62'(1 << 29)) >> 30) : r));
          esum <= esum + 34'(u[17] ? 31'd0 :
                  (u[16] ? 31'((mprod + 62'(1 << 29)) >> 30) : r));
          if (k == n) k <= 3'd0;
          else k <= k + 3'd1;
        end
        if (bitn == 5'd16 && mode) begin
          if (u[17]) r <= '0;
          else if (u[16]) r <= 31'((mprod + 62'(1 << 29)) >> 30);
        end
      end
      ptcp_pkg::ST_LOG_DIV: if (div_done) begin
        logic [30:0] q;
        q = (div_q > 61'(OneQ30)) ? OneQ30 : div_q[30:0];
        pstar[k] <= (zval[k] < 0) ? OneQ30 - q : q;
        if (k == n) k <= 3'd0;
        else k <= k + 3'd1;
      end
      ptcp_pkg::ST_NORM_DIV: if (div_done) begin
        prob[k] <= (div_q > 61'd65535) ? 16'hFFFF : div_q[15:0];
        if (k == n) k <= 3'd0;
        else k <= k + 3'd1;
      end
      ptcp_pkg::ST_EMIT: if (!result_stall) k <= k + 3'd1;
      default: ;
    endcase
  end

  // Graded response: category difference computed at emit time.
  logic [30:0] ps_hi, ps_lo;
  logic [31:0] gdiff;
  logic [17:0] grnd;
  assign ps_hi = pstar[k];
  assign ps_lo = (k == n) ? 31'd0 : pstar[k + 3'd1];
  assign gdiff = (ps_hi > ps_lo) ? 32'(ps_hi - ps_lo) : 32'd0;
  assign grnd = 18'((gdiff + 32'd8192) >> 14);

  assign theta_stall = (state != ptcp_pkg::ST_IDLE);
  assign result_valid = (state == ptcp_pkg::ST_EMIT);
  assign category = k;
  assign last = (k == n);
  assign probability = (n == 3'd0) ? 16'hFFFF :
                       (mode ? ((grnd > 18'd65535) ? 16'hFFFF : grnd[15:0]) : prob[k]);

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> theta_stall) else $error("result while accepting input");
  a_cat_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (k <= n)) else $error("category past last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(k))
    else $error("stalled result moved");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for polytomous_item_category_probs
// Sends ability values through the input channel and checks every category
// probability against a local fixed point predictor of both scoring modes.
// The tests run under several configurations; the random traffic test adds random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WatchdogLimit = 20000;
  localparam logic [2:0] RegUnused = 3'd7;

  typedef struct {
    logic [2:0]  cat;
    logic [15:0] prob;
    logic        last;
  } cat_prob_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               theta_valid = 1'b0;
  logic               theta_stall;
  logic signed [15:0] theta = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [2:0]         category;
  logic [15:0]        probability;
  logic               last;

  // Local copy of the configuration registers.
  logic        mode_q = 1'b0;
  logic [14:0] disc_q = 15'd4096;
  logic [2:0]  count_q = 3'd1;
  logic [15:0] thr_q [ptcp_pkg::NumThrRegs];

  cat_prob_t expected_probs[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  // exp(-2^(i-12)) in Q1.30, one entry per bit of the exponent argument.
  longint unsigned exp_factor [ptcp_pkg::ExpSteps] = '{
    1073479712, 1073217664, 1072693760, 1071646719, 1069555701,
    1065385899, 1057095000, 1040706261, 1008687096, 947573834,
    836230973, 651257337, 395007542, 145315154, 19666268,
    360200, 121
  };

  polytomous_item_category_probs i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .theta_valid  (theta_valid),
    .theta_stall  (theta_stall),
    .theta        (theta),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .category     (category),
    .probability  (probability),
    .last         (last)
  );

  always #6 clk = ~clk;

  // Output stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // exp(-u) in Q1.30 for a nonnegative Q.12 argument.
  function automatic longint unsigned exp_neg_q30(longint unsigned u);
    longint unsigned r;
    r = 64'd1 << 30;
    if (u >= (64'd1 << ptcp_pkg::ExpSteps)) return 0;
    for (int i = 0; i < ptcp_pkg::ExpSteps; i++) begin
      if (u[i]) r = (r * exp_factor[i] + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

  function automatic longint unsigned logistic_q30(longint z);
    longint unsigned mag, d, q;
    mag = (z < 0) ? longint'(-z) : longint'(z);
    d = (64'd1 << 30) + exp_neg_q30(mag);
    q = ((64'd1 << 60) + d / 2) / d;
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    return (z < 0) ? (64'd1 << 30) - q : q;
  endfunction

  function automatic logic [15:0] sat16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Works out every category probability for one ability value.
  task automatic predict_categories(logic signed [15:0] th);
    int              n;
    longint          z [ptcp_pkg::NumThrRegs + 1];
    longint          s [ptcp_pkg::NumThrRegs + 1];
    longint          m;
    longint unsigned e [ptcp_pkg::NumThrRegs + 1];
    longint unsigned ps [ptcp_pkg::NumThrRegs + 2];
    longint unsigned total, diff;
    logic [15:0]     p;
    cat_prob_t       item;
    n = (count_q > ptcp_pkg::NumThrRegs) ? ptcp_pkg::NumThrRegs : count_q;
    if (n > ptcp_pkg::MaxThresholdsDefault) n = ptcp_pkg::MaxThresholdsDefault;
    z[0] = 0;
    for (int k = 1; k <= n; k++) begin
      z[k] = (longint'(disc_q) *
              (longint'(th) - longint'($signed(thr_q[k - 1])))) >>> 12;
    end
    s[0] = 0;
    m = 0;
    for (int k = 1; k <= n; k++) begin
      s[k] = s[k - 1] + z[k];
      if (s[k] > m) m = s[k];
    end
    total = 0;
    for (int k = 0; k <= n; k++) begin
      e[k] = exp_neg_q30(longint'(m - s[k]));
      total += e[k];
    end
    ps[0] = 64'd1 << 30;
    for (int k = 1; k <= n; k++) ps[k] = logistic_q30(z[k]);
    ps[n + 1] = 0;
    for (int k = 0; k <= n; k++) begin
      if (mode_q == 1'b0) begin
        p = sat16((e[k] * 65536 + total / 2) / total);
      end else begin
        diff = (ps[k] > ps[k + 1]) ? ps[k] - ps[k + 1] : 0;
        p = sat16((diff + (64'd1 << 13)) >> 14);
      end
      item.cat = k[2:0];
      item.prob = p;
      item.last = (k == n);
      expected_probs.push_back(item);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Compares each result transfer with the oldest expected category.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_probs.size() == 0) begin
        report_mismatch("unexpected result, category", category, -1);
      end else begin
        cat_prob_t want;
        want = expected_probs.pop_front();
        if (category !== want.cat) report_mismatch("category", category, want.cat);
        if (probability !== want.prob) report_mismatch("probability", probability, want.prob);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (theta_valid && !theta_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one ability value and records its expected categories.
  task automatic send_theta(logic signed [15:0] th);
    while ($urandom_range(99) < send_idle_pct) begin
      theta_valid = 1'b0;
      theta = 16'($urandom);
      @(negedge clk);
    end
    theta_valid = 1'b1;
    theta = th;
    do @(posedge clk); while (!(theta_valid && !theta_stall));
    predict_categories(th);
    @(negedge clk);
  endtask

  // Waits until every expected category has been transferred.
  task automatic drain_results();
    theta_valid = 1'b0;
    while (expected_probs.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ptcp_pkg::RegMode:  mode_q = value[0];
      ptcp_pkg::RegDisc:  disc_q = value[14:0];
      ptcp_pkg::RegCount: count_q = value[2:0];
      ptcp_pkg::RegThr1, ptcp_pkg::RegThr1 + 3'd1, ptcp_pkg::RegThr1 + 3'd2,
      ptcp_pkg::RegThr1 + 3'd3:
        thr_q[2'(idx - ptcp_pkg::RegThr1)] = value;
      default: ;
    endcase
  endtask

  task automatic write_config(logic md, logic [15:0] a, logic [2:0] cnt,
                              logic [15:0] b1, logic [15:0] b2,
                              logic [15:0] b3, logic [15:0] b4);
    drain_results();
    write_reg(ptcp_pkg::RegMode, {15'd0, md});
    write_reg(ptcp_pkg::RegDisc, a);
    write_reg(ptcp_pkg::RegCount, {13'd0, cnt});
    write_reg(ptcp_pkg::RegThr1, b1);
    write_reg(ptcp_pkg::RegThr1 + 3'd1, b2);
    write_reg(ptcp_pkg::RegThr1 + 3'd2, b3);
    write_reg(ptcp_pkg::RegThr1 + 3'd3, b4);
  endtask

  // Reset values: one threshold at zero, slope 1.0, softmax mode.
  task automatic test_reset_config();
    send_theta(16'sh8000);
    send_theta(16'sh7FFF);
    send_theta(16'sd0);
    send_theta(-16'sd1);
  endtask

  // Softmax with zero thresholds, too many thresholds and extreme slopes.
  task automatic test_softmax_directed();
    write_config(1'b0, 16'd4096, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_theta(16'sd1234);
    write_config(1'b0, 16'h7FFF, 3'd7, 16'h8000, 16'h7FFF, 16'hF000, 16'h1000);
    send_theta(16'sh7FFF);
    send_theta(16'sh8000);
    send_theta(16'sd0);
    write_config(1'b0, 16'd0, 3'd4, 16'h1000, 16'hE000, 16'h0000, 16'h2000);
    send_theta(16'sd5000);
    write_config(1'b0, 16'hFFFF, 3'd2, 16'h0800, 16'hF800, 16'h0000, 16'h0000);
    send_theta(-16'sd4096);
  endtask

  // Graded response, including unordered thresholds and saturated ends.
  task automatic test_graded_directed();
    write_config(1'b1, 16'd4096, 3'd3, 16'hE000, 16'h0000, 16'h2000, 16'h0000);
    send_theta(16'sd0);
    send_theta(16'sh7FFF);
    send_theta(16'sh8000);
    write_config(1'b1, 16'd8192, 3'd4, 16'h2000, 16'hE000, 16'h1000, 16'hF000);
    send_theta(16'sd100);
    send_theta(-16'sd8000);
    write_config(1'b1, 16'h7FFF, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_theta(16'sd77);
  endtask

  // A write to an index with no register must leave the setup unchanged.
  task automatic test_unused_index();
    write_config(1'b0, 16'd6000, 3'd2, 16'hF000, 16'h1000, 16'h0000, 16'h0000);
    write_reg(RegUnused, 16'hFFFF);
    send_theta(16'sd2048);
    send_theta(-16'sd2048);
  endtask

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_theta();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  // Random ability values under random setups and each idling pattern.
  task automatic test_random_traffic();
    int send_pcts [4] = '{0, 48, 0, 30};
    int recv_pcts [4] = '{0, 0, 48, 30};
    logic [15:0] a;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(3))
          0: a = 16'h7FFF;
          1: a = 16'($urandom_range(0, 1024));
          default: a = 16'($urandom);
        endcase
        write_config(1'($urandom_range(1)), a, 3'($urandom_range(7)),
                     pick_threshold(), pick_threshold(), pick_threshold(),
                     pick_threshold());
        for (int i = 0; i < 16; i++) send_theta(pick_theta());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ptcp_pkg::NumThrRegs; i++) thr_q[i] = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_softmax_directed();
    test_graded_directed();
    test_unused_index();
    test_random_traffic();
    drain_results();
    repeat (500) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
